### rtl/tta_pkg.sv
// Shared constants, codes and types for the thermal threshold arbiter.
package tta_pkg;

  localparam int TRIP_W           = 16;
  localparam int CMD_W            = 2;
  localparam int IDX_W            = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_W            = 16;
  localparam int TRIP_OFFSET      = 2742;
  localparam int NUM_POLICIES_DEF = 16;

  typedef logic [TRIP_W-1:0] trip_t;

  localparam logic [CMD_W-1:0] CMD_TRIAL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_HIGH = 2'd3;

  localparam trip_t ALLOWED_LOW_RST  = 16'd2732;
  localparam trip_t ALLOWED_HIGH_RST = 16'd5282;
  localparam trip_t DEFAULT_LOW_RST  = 16'd2732;
  localparam trip_t DEFAULT_HIGH_RST = 16'd5282;

  // one stored trip pair as it sits in the entry RAM
  typedef struct packed {
    trip_t lower;
    trip_t upper;
  } trip_pair_t;

  // latched request under evaluation
  typedef struct packed {
    logic  wr;     // commit or remove: entry gets written back
    logic  lv;
    trip_t lo;
    logic  uv;
    trip_t up;
  } req_t;

endpackage

### rtl/thermal_threshold_arbiter_top.sv
// Thermal threshold arbiter top: request sequencer, table scan and result register.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | cmd, policy_index, trips, temp, hysteresis
//  out_    | output    | out_valid / out_stall  | status, result_lower/upper, changed
//  cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// A trial, commit or remove of a present entry scans the table: the scan reads one RAM entry
// per cycle through the registered read port, then the finish state clamps/compares and the
// response state loads the output. Rejected requests and removes of absent entries go
// straight to the response state. A new request is taken only once the block is idle again.
// Synchronous active-low reset clears the presence/valid flags, arbitrated pair and control flags and reloads config.
// A stalled output holds the block in its response state; in_stall stays high until then.
module thermal_threshold_arbiter_top import tta_pkg::*; #(
  parameter int NUM_POLICIES = NUM_POLICIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [IDX_W-1:0]     in_policy_index,
  input  logic                 in_lower_valid,
  input  logic [TRIP_W-1:0]    in_lower_trip,
  input  logic                 in_upper_valid,
  input  logic [TRIP_W-1:0]    in_upper_trip,
  input  logic [TRIP_W-1:0]    in_current_temp,
  input  logic [TRIP_W-1:0]    in_hysteresis,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic [TRIP_W-1:0]    out_result_lower,
  output logic [TRIP_W-1:0]    out_result_upper,
  output logic                 out_changed,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (NUM_POLICIES > 1) ? $clog2(NUM_POLICIES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  function automatic trip_t clamp_trip(trip_t v, trip_t lo, trip_t hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  logic [1:0] state_r, state_nxt;

  // configuration
  trip_t allowed_low_r, allowed_high_r, default_low_r, default_high_r;

  // per-entry flags, cleared by reset
  logic [NUM_POLICIES-1:0] present_r, lv_flag_r, uv_flag_r;

  // arbitrated state
  trip_t arb_lower_r, arb_upper_r;
  logic  arb_valid_r, change_flag_r;

  // request under evaluation
  req_t          req_r;
  logic [AW-1:0] req_addr_r;

  // scan pipeline
  logic          issue_r;
  logic [AW-1:0] rd_cnt_r;
  logic          s1_vld_r, s1_last_r, s1_pres_r, s1_lv_r, s1_uv_r;
  logic [AW-1:0] s1_idx_r;
  trip_pair_t    rd_data;
  logic          have_lo_r, have_up_r;
  trip_t         best_lo_r, best_up_r;

  // response staging and output register
  logic  res_status_r;
  trip_t res_lo_r, res_up_r;
  logic  out_valid_r, out_status_r, out_changed_r;
  trip_t out_lo_r, out_up_r;

  // ---------------- accept-time decode ----------------
  logic              in_acc;
  logic              idx_ok, is_trial, is_commit, is_rm, bad, reject, rm_absent, go_scan;
  logic [AW-1:0]     in_addr;
  logic signed [17:0] lo_chk, cur_s;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign idx_ok    = int'(in_policy_index) < NUM_POLICIES;
  assign in_addr   = AW'(in_policy_index);
  assign is_trial  = (in_cmd == CMD_TRIAL);
  assign is_commit = (in_cmd == CMD_COMMIT);
  assign is_rm     = (in_cmd == CMD_REMOVE);

  assign cur_s  = $signed({2'b00, in_current_temp});
  assign lo_chk = $signed({2'b00, in_lower_trip}) - $signed({2'b00, in_hysteresis})
                  - $signed(18'(TRIP_OFFSET));
  assign bad    = (in_lower_valid && (lo_chk > cur_s)) ||
                  (in_upper_valid && (in_upper_trip < in_current_temp));

  assign reject    = !idx_ok || !(is_trial || is_commit || is_rm) ||
                     ((is_trial || is_commit) && bad);
  assign rm_absent = is_rm && idx_ok && !present_r[in_addr];
  assign go_scan   = !reject && !rm_absent;

  // ---------------- entry RAM ----------------
  logic       ram_we;
  trip_pair_t ram_wdata;

  assign ram_we    = (state_r == ST_FIN) && req_r.wr;
  assign ram_wdata = '{lower: req_r.lo, upper: req_r.up};

  tta_entry_ram #(
    .DEPTH (NUM_POLICIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_addr_r),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r),
    .rdata (rd_data)
  );

  // ---------------- scan data path ----------------
  // the requested entry is substituted in place of the stored one
  logic  sub, e_pres, e_lv, e_uv;
  trip_t e_lo, e_up;

  assign sub    = (s1_idx_r == req_addr_r);
  assign e_pres = sub ? 1'b1     : s1_pres_r;
  assign e_lv   = sub ? req_r.lv : s1_lv_r;
  assign e_uv   = sub ? req_r.uv : s1_uv_r;
  assign e_lo   = sub ? req_r.lo : rd_data.lower;
  assign e_up   = sub ? req_r.up : rd_data.upper;

  trip_t fin_lo, fin_up;
  logic  pair_diff;

  assign fin_lo    = have_lo_r ? clamp_trip(best_lo_r, allowed_low_r, allowed_high_r)
                               : default_low_r;
  assign fin_up    = have_up_r ? clamp_trip(best_up_r, allowed_low_r, allowed_high_r)
                               : default_high_r;
  assign pair_diff = !arb_valid_r || (fin_lo != arb_lower_r) || (fin_up != arb_upper_r);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = go_scan ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (s1_vld_r && s1_last_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      allowed_low_r  <= ALLOWED_LOW_RST;
      allowed_high_r <= ALLOWED_HIGH_RST;
      default_low_r  <= DEFAULT_LOW_RST;
      default_high_r <= DEFAULT_HIGH_RST;
      present_r      <= '0;
      lv_flag_r      <= '0;
      uv_flag_r      <= '0;
      arb_lower_r    <= '0;
      arb_upper_r    <= '0;
      arb_valid_r    <= 1'b0;
      change_flag_r  <= 1'b0;
      issue_r        <= 1'b0;
      s1_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_ALLOWED_LOW:  allowed_low_r  <= cfg_data;
          REG_ALLOWED_HIGH: allowed_high_r <= cfg_data;
          REG_DEFAULT_LOW:  default_low_r  <= cfg_data;
          REG_DEFAULT_HIGH: default_high_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc && rm_absent) begin
        change_flag_r <= 1'b0;
      end

      if (in_acc && go_scan) begin
        issue_r <= 1'b1;
      end else if (issue_r && (rd_cnt_r == AW'(NUM_POLICIES - 1))) begin
        issue_r <= 1'b0;
      end
      s1_vld_r <= issue_r;

      if (state_r == ST_FIN) begin
        if (req_r.wr) begin
          present_r[req_addr_r] <= 1'b1;
          lv_flag_r[req_addr_r] <= req_r.lv;
          uv_flag_r[req_addr_r] <= req_r.uv;
          if (pair_diff) begin
            arb_lower_r   <= fin_lo;
            arb_upper_r   <= fin_up;
            arb_valid_r   <= 1'b1;
            change_flag_r <= 1'b1;
          end else begin
            change_flag_r <= 1'b0;
          end
        end
      end

      if ((state_r == ST_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_addr_r   <= in_addr;
      req_r.wr     <= is_commit || is_rm;
      req_r.lv     <= is_rm ? 1'b0 : in_lower_valid;
      req_r.lo     <= (is_rm || !in_lower_valid) ? '0 : in_lower_trip;
      req_r.uv     <= is_rm ? 1'b0 : in_upper_valid;
      req_r.up     <= (is_rm || !in_upper_valid) ? '0 : in_upper_trip;
      rd_cnt_r     <= '0;
      have_lo_r    <= 1'b0;
      have_up_r    <= 1'b0;
      best_lo_r    <= '0;
      best_up_r    <= '0;
      res_status_r <= reject;
      res_lo_r     <= arb_lower_r;
      res_up_r     <= arb_upper_r;
    end

    if (issue_r) begin
      rd_cnt_r  <= rd_cnt_r + AW'(1);
      s1_idx_r  <= rd_cnt_r;
      s1_last_r <= (rd_cnt_r == AW'(NUM_POLICIES - 1));
      s1_pres_r <= present_r[rd_cnt_r];
      s1_lv_r   <= lv_flag_r[rd_cnt_r];
      s1_uv_r   <= uv_flag_r[rd_cnt_r];
    end

    if (s1_vld_r && e_pres) begin
      if (e_lv && (!have_lo_r || (e_lo > best_lo_r))) begin
        best_lo_r <= e_lo;
        have_lo_r <= 1'b1;
      end
      if (e_uv && (!have_up_r || (e_up < best_up_r))) begin
        best_up_r <= e_up;
        have_up_r <= 1'b1;
      end
    end

    // trial result and the new stored pair are both the freshly arbitrated pair
    if (state_r == ST_FIN) begin
      res_status_r <= 1'b0;
      res_lo_r     <= fin_lo;
      res_up_r     <= fin_up;
    end

    if ((state_r == ST_RESP) && out_free) begin
      out_status_r  <= res_status_r;
      out_lo_r      <= res_lo_r;
      out_up_r      <= res_up_r;
      out_changed_r <= change_flag_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_lower = out_lo_r;
  assign out_result_upper = out_up_r;
  assign out_changed      = out_changed_r;

  // ---------------- assertions ----------------
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("output transaction raised outside the response state");

  a_fin_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> $past(state_r) == ST_SCAN)
    else $error("finish state entered without a table scan");

  a_issue_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r |-> (state_r == ST_SCAN))
    else $error("table read issued outside the scan");

  a_commit_sets_arb: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && req_r.wr) |=> arb_valid_r)
    else $error("arbitrated pair not marked valid after a write-back");

endmodule

### rtl/tta_entry_ram.sv
// Entry RAM: one write port, one registered read port, holds the trip pairs.
module tta_entry_ram import tta_pkg::*; #(
  parameter int DEPTH = NUM_POLICIES_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  trip_pair_t    wdata,
  input  logic [AW-1:0] raddr,
  output trip_pair_t    rdata
);

  trip_pair_t mem [DEPTH];
  trip_pair_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sim/thermal_threshold_arbiter_checker.sv
// Reply checker for the thermal threshold arbiter: mirrors the policy table, predicts, compares.
module thermal_threshold_arbiter_checker import tta_pkg::*; #(
  parameter int NUM_POLICIES = NUM_POLICIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [IDX_W-1:0]     in_policy_index,
  input  logic                 in_lower_valid,
  input  logic [TRIP_W-1:0]    in_lower_trip,
  input  logic                 in_upper_valid,
  input  logic [TRIP_W-1:0]    in_upper_trip,
  input  logic [TRIP_W-1:0]    in_current_temp,
  input  logic [TRIP_W-1:0]    in_hysteresis,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_status,
  input  logic [TRIP_W-1:0]    out_result_lower,
  input  logic [TRIP_W-1:0]    out_result_upper,
  input  logic                 out_changed,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   waiting,
  output int                   checked
);

  typedef struct packed {
    logic  status;
    trip_t lower;
    trip_t upper;
    logic  changed;
  } reply_t;

  // mirror of the policy table and the arbitrated pair
  logic  present   [NUM_POLICIES];
  logic  lower_ok  [NUM_POLICIES];
  logic  upper_ok  [NUM_POLICIES];
  trip_t lower_req [NUM_POLICIES];
  trip_t upper_req [NUM_POLICIES];
  trip_t arb_lo;
  trip_t arb_up;
  logic  arb_set;
  logic  chg_flag;

  trip_t lim_low;
  trip_t lim_high;
  trip_t dflt_low;
  trip_t dflt_high;

  reply_t reply_q [$];
  int     n_bad  = 0;
  int     n_done = 0;

  function automatic trip_t clamp_trip(trip_t v);
    if (v < lim_low) return lim_low;
    if (v > lim_high) return lim_high;
    return v;
  endfunction

  // max of valid lower trips, min of valid upper trips, clamped or defaulted; one entry may be swapped in
  function automatic trip_pair_t scan_table(logic swap, int unsigned sub, logic lv, trip_t lo,
                                            logic uv, trip_t up);
    trip_pair_t res;
    logic       have_lo, have_up, p, elv, euv;
    trip_t      best_lo, best_up, el, eu;
    have_lo = 1'b0;
    have_up = 1'b0;
    best_lo = '0;
    best_up = '0;
    for (int i = 0; i < NUM_POLICIES; i++) begin
      p   = present[i];
      elv = lower_ok[i];
      euv = upper_ok[i];
      el  = lower_req[i];
      eu  = upper_req[i];
      if (swap && i == sub) begin
        p   = 1'b1;
        elv = lv;
        el  = lo;
        euv = uv;
        eu  = up;
      end
      if (p) begin
        if (elv && (!have_lo || el > best_lo)) begin
          best_lo = el;
          have_lo = 1'b1;
        end
        if (euv && (!have_up || eu < best_up)) begin
          best_up = eu;
          have_up = 1'b1;
        end
      end
    end
    res.lower = have_lo ? clamp_trip(best_lo) : dflt_low;
    res.upper = have_up ? clamp_trip(best_up) : dflt_high;
    return res;
  endfunction

  function automatic void store_entry(int unsigned idx, logic lv, trip_t lo, logic uv, trip_t up);
    trip_pair_t pair;
    present[idx]   = 1'b1;
    lower_ok[idx]  = lv;
    lower_req[idx] = lv ? lo : '0;
    upper_ok[idx]  = uv;
    upper_req[idx] = uv ? up : '0;
    pair = scan_table(1'b0, 0, 1'b0, '0, 1'b0, '0);
    if (!arb_set || pair.lower != arb_lo || pair.upper != arb_up) begin
      arb_lo   = pair.lower;
      arb_up   = pair.upper;
      arb_set  = 1'b1;
      chg_flag = 1'b1;
    end else begin
      chg_flag = 1'b0;
    end
  endfunction

  function automatic reply_t predict_reply(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                           logic lv, trip_t lo, logic uv, trip_t up,
                                           trip_t cur, trip_t hys);
    reply_t     r;
    trip_pair_t pair;
    int         s_lo, s_up, s_cur, s_hys;
    logic       bad;
    s_lo     = lo;
    s_up     = up;
    s_cur    = cur;
    s_hys    = hys;
    r.status = 1'b0;
    r.lower  = arb_lo;
    r.upper  = arb_up;
    if ((cmd != CMD_TRIAL && cmd != CMD_COMMIT && cmd != CMD_REMOVE) ||
        int'(idx) >= NUM_POLICIES) begin
      r.status = 1'b1;
    end else if (cmd == CMD_REMOVE) begin
      // a present entry is kept but loses both trips; an absent one only clears the flag
      if (present[idx]) store_entry(idx, 1'b0, '0, 1'b0, '0);
      else chg_flag = 1'b0;
      r.lower = arb_lo;
      r.upper = arb_up;
    end else begin
      bad = (lv && (s_lo - s_hys - TRIP_OFFSET > s_cur)) || (uv && s_up < s_cur);
      if (bad) begin
        r.status = 1'b1;
      end else if (cmd == CMD_TRIAL) begin
        pair    = scan_table(1'b1, idx, lv, lo, uv, up);
        r.lower = pair.lower;
        r.upper = pair.upper;
      end else begin
        store_entry(idx, lv, lo, uv, up);
        r.lower = arb_lo;
        r.upper = arb_up;
      end
    end
    r.changed = chg_flag;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    reply_t want, got;
    logic   bad;
    if (!rst_n) begin
      for (int i = 0; i < NUM_POLICIES; i++) begin
        present[i]   = 1'b0;
        lower_ok[i]  = 1'b0;
        upper_ok[i]  = 1'b0;
        lower_req[i] = '0;
        upper_req[i] = '0;
      end
      arb_lo    = '0;
      arb_up    = '0;
      arb_set   = 1'b0;
      chg_flag  = 1'b0;
      lim_low   = ALLOWED_LOW_RST;
      lim_high  = ALLOWED_HIGH_RST;
      dflt_low  = DEFAULT_LOW_RST;
      dflt_high = DEFAULT_HIGH_RST;
      reply_q.delete();
    end else begin
      // a reply never belongs to the request taken at the same edge, so compare first
      if (out_valid && !out_stall) begin
        got.status  = out_status;
        got.lower   = out_result_lower;
        got.upper   = out_result_upper;
        got.changed = out_changed;
        if (reply_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] reply with none expected: status %0b lower %0d upper %0d changed %0b",
                     $realtime, got.status, got.lower, got.upper, got.changed);
        end else begin
          want = reply_q.pop_front();
          bad  = (got.status !== want.status) || (got.lower !== want.lower) ||
                 (got.upper !== want.upper) || (got.changed !== want.changed);
          n_done++;
          if (bad) begin
            n_bad++;
            if (n_bad <= 10)
              $display("[%0t] reply %0d exp/got: st %0b/%0b lo %0d/%0d up %0d/%0d chg %0b/%0b",
                       $realtime, n_done, want.status, got.status, want.lower, got.lower,
                       want.upper, got.upper, want.changed, got.changed);
          end
        end
      end
      if (in_valid && !in_stall)
        reply_q.push_back(predict_reply(in_cmd, in_policy_index, in_lower_valid, in_lower_trip,
                                        in_upper_valid, in_upper_trip, in_current_temp,
                                        in_hysteresis));
      if (cfg_we) begin
        case (cfg_index)
          REG_ALLOWED_LOW:  lim_low   = cfg_data;
          REG_ALLOWED_HIGH: lim_high  = cfg_data;
          REG_DEFAULT_LOW:  dflt_low  = cfg_data;
          REG_DEFAULT_HIGH: dflt_high = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches <= n_bad;
    waiting    <= reply_q.size();
    checked    <= n_done;
  end

endmodule

### sim/thermal_threshold_arbiter_top_test.sv
// Testbench top for the thermal threshold arbiter: clock, reset, request stimulus and verdict.
module thermal_threshold_arbiter_top_test import tta_pkg::*;;

  localparam int NPOL        = NUM_POLICIES_DEF;
  localparam int ITEMS_PER   = 247;
  localparam int NUM_SETS    = 7;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {RX_FREE, RX_COIN, RX_EVERY4, RX_HEAVY} rx_mode_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd          = '0;
  logic [IDX_W-1:0]     in_policy_index = '0;
  logic                 in_lower_valid  = 1'b0;
  logic [TRIP_W-1:0]    in_lower_trip   = '0;
  logic                 in_upper_valid  = 1'b0;
  logic [TRIP_W-1:0]    in_upper_trip   = '0;
  logic [TRIP_W-1:0]    in_current_temp = '0;
  logic [TRIP_W-1:0]    in_hysteresis   = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic                 out_status;
  logic [TRIP_W-1:0]    out_result_lower;
  logic [TRIP_W-1:0]    out_result_upper;
  logic                 out_changed;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_W-1:0]     cfg_data        = '0;

  int mismatches;
  int waiting;
  int checked;

  int burst_left = 0;
  int cmd_count [4];

  always #5 clk = ~clk;

  thermal_threshold_arbiter_top #(.NUM_POLICIES(NPOL)) dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_policy_index, .in_lower_valid, .in_lower_trip,
    .in_upper_valid, .in_upper_trip, .in_current_temp, .in_hysteresis,
    .out_valid, .out_stall, .out_status, .out_result_lower, .out_result_upper, .out_changed,
    .cfg_we, .cfg_index, .cfg_data
  );

  thermal_threshold_arbiter_checker #(.NUM_POLICIES(NPOL)) chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_policy_index, .in_lower_valid, .in_lower_trip,
    .in_upper_valid, .in_upper_trip, .in_current_temp, .in_hysteresis,
    .out_valid, .out_stall, .out_status, .out_result_lower, .out_result_upper, .out_changed,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .waiting, .checked
  );

  // receiver: changing stall patterns, plus a long hold-off now and then so the block backs up
  rx_mode_t rx_mode   = RX_FREE;
  int       rx_left   = 0;
  int       rx_seen   = 0;
  int       hold_left = 0;
  int       next_hold = 400;

  always @(posedge clk) begin
    if (out_valid && !out_stall) rx_seen++;
    if (rx_seen >= next_hold && hold_left == 0) begin
      hold_left = 250;
      next_hold += 900;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_COIN:   out_stall <= 1'($urandom_range(0, 1));
        RX_EVERY4: out_stall <= (rx_left % 4 == 0);
        default:   out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: %0d cycles without a transaction", quiet);
    $display("CHECK FAILED");
    $finish;
  end

  // offer one request and hold it until the block takes it; bursts with random gaps
  task automatic send_req(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, logic lv, trip_t lo,
                          logic uv, trip_t up, trip_t cur, trip_t hys);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_policy_index <= idx;
    in_lower_valid  <= lv;
    in_lower_trip   <= lo;
    in_upper_valid  <= uv;
    in_upper_trip   <= up;
    in_current_temp <= cur;
    in_hysteresis   <= hys;
    do @(posedge clk); while (in_stall);
    burst_left--;
    cmd_count[cmd]++;
  endtask

  task automatic send_random_req();
    logic [CMD_W-1:0] c;
    logic [IDX_W-1:0] ix;
    logic             lv, uv;
    trip_t            lo, up, cur, hys;
    int               pick, tmp;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // noise: every field fully random
      c   = CMD_W'($urandom_range(0, 3));
      ix  = IDX_W'($urandom);
      lv  = 1'($urandom);
      lo  = trip_t'($urandom);
      uv  = 1'($urandom);
      up  = trip_t'($urandom);
      cur = trip_t'($urandom);
      hys = trip_t'($urandom);
    end else begin
      pick = $urandom_range(0, 99);
      c = (pick < 50) ? CMD_COMMIT : (pick < 80) ? CMD_TRIAL :
          (pick < 97) ? CMD_REMOVE : CMD_UNUSED;
      ix  = IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, NPOL - 1));
      cur = trip_t'($urandom_range(2600, 4200));
      hys = trip_t'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 100));
      lv  = ($urandom_range(0, 3) != 0);
      uv  = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // right at the lower-trip rejection edge
        tmp = int'(cur) + int'(hys) + TRIP_OFFSET - 1 + int'($urandom_range(0, 2));
        lo  = trip_t'(tmp);
      end else begin
        lo = trip_t'($urandom_range(2000, 6500));
      end
      case ($urandom_range(0, 9))
        0: begin
          tmp = int'(cur) - 1 + int'($urandom_range(0, 2));
          up  = trip_t'(tmp);
        end
        1:       up = trip_t'($urandom_range(0, cur));
        default: up = trip_t'(cur + $urandom_range(0, 2500));
      endcase
    end
    send_req(c, ix, lv, lo, uv, up, cur, hys);
  endtask

  // stop offering and wait until every reply is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (NPOL + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, trip_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(int set_no);
    trip_t a, b, c, d;
    case (set_no)
      1: begin
        a = '0; b = '1; c = '0; d = '1;
      end
      2: begin
        // fully crossed clamp window
        a = '1; b = '0; c = '1; d = '0;
      end
      3: begin
        a = 16'd5000; b = 16'd3000; c = trip_t'($urandom); d = trip_t'($urandom);
      end
      4: begin
        a = 16'd3000; b = 16'd3100; c = 16'd3050; d = 16'd3060;
      end
      5: begin
        a = trip_t'($urandom); b = trip_t'($urandom);
        c = trip_t'($urandom); d = trip_t'($urandom);
      end
      default: begin
        a = ALLOWED_LOW_RST; b = ALLOWED_HIGH_RST; c = DEFAULT_LOW_RST; d = DEFAULT_HIGH_RST;
      end
    endcase
    write_reg(REG_ALLOWED_LOW, a);
    write_reg(REG_ALLOWED_HIGH, b);
    write_reg(REG_DEFAULT_LOW, c);
    write_reg(REG_DEFAULT_HIGH, d);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the reset register values
    send_req(CMD_REMOVE, 4'd5, 1'b0, '0, 1'b0, '0, 16'd3000, 16'd0);       // absent entry
    send_req(CMD_TRIAL, 4'd0, 1'b1, '0, 1'b1, '1, '0, '0);                 // clamps both ways
    send_req(CMD_COMMIT, 4'd0, 1'b1, '0, 1'b1, '1, '0, '0);
    send_req(CMD_COMMIT, 4'd0, 1'b1, '0, 1'b1, '1, '0, '0);                // same pair again
    send_req(CMD_COMMIT, 4'd15, 1'b1, '1, 1'b0, '0, '0, '0);               // lower far too high
    send_req(CMD_COMMIT, 4'd15, 1'b1, 16'd2742, 1'b0, '0, '0, '0);         // lower on the edge
    send_req(CMD_COMMIT, 4'd14, 1'b1, 16'd2743, 1'b0, '0, '0, '0);         // one past it
    send_req(CMD_COMMIT, 4'd1, 1'b0, '0, 1'b1, 16'd2999, 16'd3000, '0);    // upper below temp
    send_req(CMD_COMMIT, 4'd1, 1'b0, '0, 1'b1, 16'd3000, 16'd3000, '0);    // upper equal temp
    send_req(CMD_COMMIT, 4'd2, 1'b1, '1, 1'b0, '0, '0, '1);                // huge hysteresis
    send_req(CMD_COMMIT, 4'd3, 1'b1, '0, 1'b1, '1, '1, '0);                // hottest temperature
    send_req(CMD_TRIAL, 4'd4, 1'b0, '1, 1'b0, '1, 16'd3000, 16'd20);
    send_req(CMD_COMMIT, 4'd5, 1'b0, '1, 1'b0, '1, 16'd3000, 16'd20);      // present, no trips
    send_req(CMD_UNUSED, 4'd6, 1'b1, 16'd3100, 1'b1, 16'd3500, 16'd3000, 16'd20);
    send_req(CMD_REMOVE, 4'd0, 1'b0, '0, 1'b0, '0, 16'd3000, 16'd0);       // present entry
    send_req(CMD_REMOVE, 4'd0, 1'b0, '0, 1'b0, '0, 16'd3000, 16'd0);
    send_req(CMD_REMOVE, 4'd9, 1'b1, '1, 1'b1, '0, '1, '1);
    send_req(CMD_TRIAL, 4'd7, 1'b0, '0, 1'b1, '0, 16'd100, 16'd0);         // rejected trial
    send_req(CMD_COMMIT, 4'd8, 1'b1, 16'd4000, 1'b1, 16'd4500, 16'd3000, 16'd10);
    send_req(CMD_TRIAL, 4'd9, 1'b1, 16'd5000, 1'b1, 16'd3200, 16'd3000, 16'd10);
    send_req(CMD_COMMIT, 4'd15, 1'b1, 16'd3500, 1'b1, 16'd3000, 16'd3000, 16'd10);
    drain();

    for (int s = 0; s < NUM_SETS; s++) begin
      if (s != 0) apply_setting(s);
      repeat (ITEMS_PER) send_random_req();
      drain();
    end

    $display("Covered %0d trial, %0d commit, %0d remove and %0d unused-code requests",
             cmd_count[CMD_TRIAL], cmd_count[CMD_COMMIT], cmd_count[CMD_REMOVE],
             cmd_count[CMD_UNUSED]);
    $display("over %0d register settings; %0d replies checked, %0d mismatches",
             NUM_SETS, checked, mismatches);
    if (mismatches == 0 && waiting == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
